// ----- hdl/sbc_pkg.sv -----
package sbc_pkg;

  localparam int BIN_W = 16;
  localparam int LEN_W = 11;
  localparam int NF_W = 5;
  localparam int IDX_W = 10;
  localparam int RB_W = 9;
  localparam int CB_W = 8;
  localparam int ACC_W = 58;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 11;
  localparam int IN_DATA_W = 64;
  localparam int OUT_DATA_W = 136;

  localparam int IN_IDX_LO = 0;
  localparam int IN_RE_LO = IN_IDX_LO + IDX_W;
  localparam int IN_IM_LO = IN_RE_LO + BIN_W;
  localparam int IN_RB_LO = IN_IM_LO + BIN_W;
  localparam int IN_CB_LO = IN_RB_LO + RB_W;

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;
  localparam logic [NF_W-1:0] NF_RESET = 5'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NF = 1'b1;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_CELL = 1'b1;

  localparam logic ST_OK = 1'b0;
  localparam logic ST_OUTSIDE = 1'b1;

  typedef struct packed {
    logic load;
    logic start;
    logic issue;
    logic out_load;
    logic [NF_W-1:0] i;
    logic [NF_W-1:0] j;
    logic ph;
  } cmd_t;

  typedef struct packed {
    logic ok;
    logic busy;
    logic [NF_W-1:0] nf;
  } stat_t;

endpackage

// ----- hdl/sbc_ctrl.sv -----
module sbc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_action,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  sbc_pkg::stat_t stat,
  output sbc_pkg::cmd_t  cmd
);
  import sbc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_RUN = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [NF_W-1:0] i_cnt;
  logic [NF_W-1:0] i_cnt_next;
  logic [NF_W-1:0] j_cnt;
  logic [NF_W-1:0] j_cnt_next;
  logic ph;
  logic ph_next;
  logic last_j;
  logic last_i;
  logic accept;

  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;
  assign last_j = (({1'b0, j_cnt} + 6'd2) >= {1'b0, stat.nf});
  assign last_i = (({1'b0, i_cnt} + 6'd1) >= {1'b0, stat.nf});

  always_comb begin
    cmd.load = accept && (in_action == ACT_LOAD);
    cmd.start = accept && (in_action == ACT_CELL);
    cmd.issue = (state == S_RUN);
    cmd.out_load = (state == S_FINISH) && (!out_valid || out_ready);
    cmd.i = i_cnt;
    cmd.j = j_cnt;
    cmd.ph = ph;
  end

  always_comb begin
    state_next = state;
    i_cnt_next = i_cnt;
    j_cnt_next = j_cnt;
    ph_next = ph;
    case (state)
      S_IDLE: begin
        if (cmd.start) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        i_cnt_next = '0;
        j_cnt_next = '0;
        ph_next = 1'b0;
        state_next = stat.ok ? S_RUN : S_FINISH;
      end
      S_RUN: begin
        if (!ph) begin
          ph_next = 1'b1;
        end else begin
          ph_next = 1'b0;
          if (!last_j) begin
            j_cnt_next = j_cnt + NF_W'(2);
          end else begin
            j_cnt_next = '0;
            if (!last_i) begin
              i_cnt_next = i_cnt + NF_W'(1);
            end else begin
              state_next = S_DRAIN;
            end
          end
        end
      end
      S_DRAIN: begin
        if (!stat.busy) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (cmd.out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      i_cnt <= '0;
      j_cnt <= '0;
      ph <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= cmd.out_load || (out_valid && !out_ready);
      i_cnt <= i_cnt_next;
      j_cnt <= j_cnt_next;
      ph <= ph_next;
    end
  end

endmodule

// ----- hdl/sbc_dp.sv -----
module sbc_dp #(
  parameter int MAX_BINS = 1024,
  parameter int MAX_CELL = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  sbc_pkg::cmd_t                      cmd,
  output sbc_pkg::stat_t                     stat,
  input  logic                               cfg_we,
  input  logic [sbc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sbc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [sbc_pkg::IN_DATA_W-1:0]      in_data,
  output logic [sbc_pkg::OUT_DATA_W-1:0]     out_data,
  output logic                               out_status
);
  import sbc_pkg::*;

  localparam int AW = $clog2(MAX_BINS);
  localparam int IW = (AW + 4 > 15) ? AW + 4 : 15;
  localparam int PW = 2 * BIN_W;
  localparam int TW = 3 * BIN_W + 1;

  logic [LEN_W-1:0] len_r;
  logic [NF_W-1:0] nf_r;
  logic [LEN_W-1:0] n_eff;
  logic [RB_W-1:0] rb_r;
  logic [CB_W-1:0] cb_r;
  logic [RB_W+NF_W-1:0] qq_c;
  logic [CB_W+NF_W-1:0] uu_c;
  logic [IW-1:0] qq_r;
  logic [IW-1:0] uu_r;
  logic ok;

  logic [IW-1:0] qa;
  logic [IW-1:0] ua;
  logic [IW-1:0] ca;
  logic [IW-1:0] wa;

  logic [2*BIN_W-1:0] mem_a [MAX_BINS];
  logic [2*BIN_W-1:0] mem_b [MAX_BINS];
  logic [2*BIN_W-1:0] mem_c [MAX_BINS];
  logic [2*BIN_W-1:0] rd_a;
  logic [2*BIN_W-1:0] rd_b;
  logic [2*BIN_W-1:0] rd_c;
  logic a_in;
  logic b_in;
  logic c_in;

  logic signed [BIN_W-1:0] ar;
  logic signed [BIN_W-1:0] ai;
  logic signed [BIN_W-1:0] br;
  logic signed [BIN_W-1:0] bi;
  logic signed [BIN_W-1:0] cr1;
  logic signed [BIN_W-1:0] ci1;
  logic signed [BIN_W-1:0] cr2;
  logic signed [BIN_W-1:0] ci2;
  logic signed [BIN_W-1:0] cr3;
  logic signed [BIN_W-1:0] ci3;
  logic signed [PW-1:0] m1;
  logic signed [PW-1:0] m2;
  logic signed [PW-1:0] m3;
  logic signed [PW-1:0] m4;
  logic signed [PW:0] pr;
  logic signed [PW:0] pi;
  logic signed [TW-1:0] t1;
  logic signed [TW-1:0] t2;
  logic signed [TW-1:0] t3;
  logic signed [TW-1:0] t4;
  logic signed [TW:0] sr;
  logic signed [TW:0] si;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_i;
  logic v1;
  logic v2;
  logic v3;
  logic v4;
  logic v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_r <= LEN_RESET;
      nf_r <= NF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEN: len_r <= cfg_data[LEN_W-1:0];
        CFG_NF: nf_r <= cfg_data[NF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(len_r) > MAX_BINS) begin
      n_eff = LEN_W'(MAX_BINS);
    end else begin
      n_eff = len_r;
    end
  end

  assign qq_c = (RB_W + NF_W)'(rb_r) * (RB_W + NF_W)'(nf_r);
  assign uu_c = (CB_W + NF_W)'(cb_r) * (CB_W + NF_W)'(nf_r);
  assign ok = (nf_r != '0) && (32'(nf_r) <= MAX_CELL)
              && ((IW'(qq_c) + IW'(1)) < IW'(n_eff >> 1))
              && ((IW'(uu_c) + IW'(1)) < IW'(n_eff >> 2));

  assign stat.ok = ok;
  assign stat.nf = nf_r;
  assign stat.busy = v1 || v2 || v3 || v4 || v5;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rb_r <= in_data[IN_RB_LO +: RB_W];
      cb_r <= in_data[IN_CB_LO +: CB_W];
    end
    qq_r <= IW'(qq_c);
    uu_r <= IW'(uu_c);
  end

  assign qa = qq_r + IW'(cmd.i) + IW'(cmd.ph);
  assign ua = uu_r + IW'(cmd.j) + IW'(cmd.ph);
  assign ca = qa + ua;
  assign wa = IW'(in_data[IN_IDX_LO +: IDX_W]);

  always_ff @(posedge clk) begin
    if (cmd.load && (32'(wa) < MAX_BINS)) begin
      mem_a[wa[AW-1:0]] <= {in_data[IN_IM_LO +: BIN_W], in_data[IN_RE_LO +: BIN_W]};
      mem_b[wa[AW-1:0]] <= {in_data[IN_IM_LO +: BIN_W], in_data[IN_RE_LO +: BIN_W]};
      mem_c[wa[AW-1:0]] <= {in_data[IN_IM_LO +: BIN_W], in_data[IN_RE_LO +: BIN_W]};
    end
    if (cmd.issue) begin
      rd_a <= mem_a[qa[AW-1:0]];
      rd_b <= mem_b[ua[AW-1:0]];
      rd_c <= mem_c[ca[AW-1:0]];
      a_in <= qa < IW'(n_eff);
      b_in <= ua < IW'(n_eff);
      c_in <= ca < IW'(n_eff);
    end
  end

  assign ar = a_in ? rd_a[BIN_W-1:0] : '0;
  assign ai = a_in ? rd_a[2*BIN_W-1:BIN_W] : '0;
  assign br = b_in ? rd_b[BIN_W-1:0] : '0;
  assign bi = b_in ? rd_b[2*BIN_W-1:BIN_W] : '0;
  assign cr1 = c_in ? rd_c[BIN_W-1:0] : '0;
  assign ci1 = c_in ? rd_c[2*BIN_W-1:BIN_W] : '0;

  always_ff @(posedge clk) begin
    m1 <= ar * br;
    m2 <= ai * bi;
    m3 <= ar * bi;
    m4 <= ai * br;
    cr2 <= cr1;
    ci2 <= ci1;
    pr <= (PW + 1)'(m1) - (PW + 1)'(m2);
    pi <= (PW + 1)'(m3) + (PW + 1)'(m4);
    cr3 <= cr2;
    ci3 <= ci2;
    t1 <= pr * cr3;
    t2 <= pi * ci3;
    t3 <= pi * cr3;
    t4 <= pr * ci3;
    sr <= (TW + 1)'(t1) + (TW + 1)'(t2);
    si <= (TW + 1)'(t3) - (TW + 1)'(t4);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc_r <= '0;
      acc_i <= '0;
    end else if (v5) begin
      acc_r <= acc_r + ACC_W'(sr);
      acc_i <= acc_i + ACC_W'(si);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {(OUT_DATA_W - 2 * ACC_W - RB_W - CB_W)'(0), cb_r, rb_r, acc_i, acc_r};
      out_status <= ok ? ST_OK : ST_OUTSIDE;
    end
  end

endmodule

// ----- hdl/smoothed_bispectrum_cell.sv -----
// Smoothed bispectrum cell.
// Items arrive on the s_ stream. An item with s_tuser at 0 loads one complex
// spectrum bin into the bin store and gives no result. An item with s_tuser
// at 1 asks for one nf-by-nf cell of the bispectrum; its result leaves on the
// m_ stream with the sums, the echoed blocks and a status flag in m_tuser.
// Configuration is written through cfg_we, cfg_index and cfg_data while the
// block is idle: index 0 sets the spectrum length, index 1 the cell size nf.
// A load is written into the bin store as it is accepted. A cell query
// passes a check state, then sends nf*2*ceil(nf/2) triple-product terms into
// the multiplier pipeline, one term per cycle, reading the three bins of each
// term from three copies of the bin store; the result register is loaded once
// the pipeline drains. A query outside the grid skips the terms.
// The input is accepted only while no query is in progress; a finished result
// waits in the output register while further loads and a further query are
// taken, and the next result waits until the receiver takes the previous one.
// A synchronous reset returns the controller to idle, empties the output and
// restores the reset configuration; the bin store is not cleared.
module smoothed_bispectrum_cell #(
  parameter int MAX_BINS = 1024,
  parameter int MAX_CELL = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // bin_index, bin_real, bin_imag, row_block, col_block
  input  logic [sbc_pkg::IN_DATA_W-1:0]      s_tdata,
  // action
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // bisp_real, bisp_imag, out_row_block, out_col_block
  output logic [sbc_pkg::OUT_DATA_W-1:0]     m_tdata,
  // status
  output logic                               m_tuser,
  input  logic                               cfg_we,
  input  logic [sbc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sbc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sbc_pkg::*;

  cmd_t cmd;
  stat_t stat;

  sbc_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(s_tvalid),
    .in_action(s_tuser),
    .in_ready(s_tready),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .stat(stat),
    .cmd(cmd)
  );

  sbc_dp #(
    .MAX_BINS(MAX_BINS),
    .MAX_CELL(MAX_CELL)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .stat(stat),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_data(s_tdata),
    .out_data(m_tdata),
    .out_status(m_tuser)
  );

endmodule
